### sv/acfcd_pkg.sv
`timescale 1ns / 1ps

package acfcd_pkg;

    // Pulse buffer geometry
    localparam int BUF_DEPTH       = 60;
    localparam int ADDR_W          = 6;
    localparam int LEN_W           = 6;
    localparam int LAG_W           = 7;
    localparam int GAIN_W          = 15;
    localparam int SAMPLE_W        = 16;
    localparam int STEP_W          = 3;
    localparam int MAX_SUB_LEN_DEF = 54;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // Pulse amplitude in Q12, gain limits in Q15, rounding constant
    localparam logic signed [SAMPLE_W-1:0] PULSE_ONE  = 16'sd4096;
    localparam logic signed [SAMPLE_W-1:0] PULSE_TWO  = 16'sd8192;
    localparam logic [GAIN_W-1:0]          GAIN_MIN   = 15'd6554;
    localparam logic [GAIN_W-1:0]          GAIN_MAX   = 15'd29491;
    localparam logic signed [31:0]         ROUND_HALF = 32'sd16384;

    // Last placement step for each rate
    localparam logic [STEP_W-1:0] LAST_STEP_FULL = 3'd7;
    localparam logic [STEP_W-1:0] LAST_STEP_HALF = 3'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              place_we;
        logic [STEP_W-1:0] place_step;
        logic              rd_a;
        logic              rd_b;
        logic              mul;
        logic              sh_we;
        logic              out_ld;
        logic              out_last;
        logic [ADDR_W-1:0] idx;
    } acfcd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic             full_rate;
        logic [LEN_W-1:0] len;
        logic [LAG_W-1:0] lag;
        logic             out_free;
    } acfcd_stat_t;

    // Quotient of a 7-bit value by eleven, by reciprocal multiply
    function automatic logic [3:0] div11(input logic [6:0] w);
        logic [14:0] prod;
        begin
            prod = {8'd0, w} * 15'd187;
            return prod[14:11];
        end
    endfunction

    // Remainder of a 7-bit value by eleven
    function automatic logic [3:0] mod11(input logic [6:0] w);
        logic [3:0] q;
        logic [6:0] r;
        begin
            q = div11(w);
            r = w - ({3'd0, q} * 7'd11);
            return r[3:0];
        end
    endfunction

    // Track number (t + off) mod 5
    function automatic logic [2:0] track5(input logic [2:0] t, input logic [1:0] off);
        logic [2:0] s;
        begin
            s = t + {1'b0, off};
            return (s >= 3'd5) ? (s - 3'd5) : s;
        end
    endfunction

    // Buffer position on an interleaved track
    function automatic logic [ADDR_W-1:0] track_pos(input logic [3:0] q, input logic [2:0] trk);
        begin
            return ({2'd0, q} * 6'd5) + {3'd0, trk};
        end
    endfunction

endpackage

### sv/acelp_fixed_codebook_decode.sv
`timescale 1ns / 1ps

// Channel  Ports                     Beat
// s_       tvalid tready tdata tuser  one subframe's index words, gain, lag, length
// m_       tvalid tready tdata tlast  one Q12 excitation sample
//
// One item runs P pulse writes, then S taps, then L samples: P is 8 pulse
// writes at full rate and 3 at half rate, S is the number of sharpening taps
// (length minus lag when the lag is nonzero and below the length, else 0), and
// L the clipped length. Each tap costs a read, a multiply and a write-back on
// the single buffer write port; each sample a read and an output load.
// Reset is synchronous; the buffer is cleared through its valid bits on every
// accepted beat, with no sweep. A stalled m_ side holds emission; the next beat
// is taken as soon as the last sample sits in the output register.

module acelp_fixed_codebook_decode #(
    parameter int MAX_SUB_LEN = acfcd_pkg::MAX_SUB_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] shape_word0, [17:10] shape_word1, [25:18] shape_word2,
    // [36:26] shape_word3, [51:37] sharpen_gain, [58:52] lag, [64:59] sub_len
    input  logic [acfcd_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] full_rate
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] sample
    output logic [acfcd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    acfcd_pkg::acfcd_cmd_t  cmd;
    acfcd_pkg::acfcd_stat_t stat;

    acfcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acfcd_datapath #(
        .MAX_SUB_LEN (MAX_SUB_LEN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/acfcd_ctrl.sv
`timescale 1ns / 1ps

module acfcd_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  acfcd_pkg::acfcd_stat_t  stat,
    output acfcd_pkg::acfcd_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_SH_RD,
        ST_SH_MUL,
        ST_SH_WR,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    state_t                           state_reg, state_next;
    logic [acfcd_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [acfcd_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic                             last_place;
    logic                             sharpen;
    logic                             idx_last;

    // Decode conditions
    assign last_place = stat.full_rate ? (step_reg == acfcd_pkg::LAST_STEP_FULL)
                                       : (step_reg == acfcd_pkg::LAST_STEP_HALF);
    assign sharpen    = (stat.lag != '0) && (stat.lag < {1'b0, stat.len});
    assign idx_last   = (({1'b0, idx_reg} + 7'd1) == {1'b0, stat.len});

    // Drive commands from the current state
    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_tvalid;
        cmd.place_we   = (state_reg == ST_PLACE);
        cmd.place_step = step_reg;
        cmd.rd_a       = (state_reg == ST_SH_RD) || (state_reg == ST_EM_RD);
        cmd.rd_b       = (state_reg == ST_SH_RD);
        cmd.mul        = (state_reg == ST_SH_MUL);
        cmd.sh_we      = (state_reg == ST_SH_WR);
        cmd.out_ld     = (state_reg == ST_EM_LD) && stat.out_free;
        cmd.out_last   = idx_last;
        cmd.idx        = idx_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequence placement, sharpening and emission
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PLACE;
                    step_next  = '0;
                end
            end
            ST_PLACE: begin
                if (last_place) begin
                    if (sharpen) begin
                        state_next = ST_SH_RD;
                        idx_next   = stat.lag[acfcd_pkg::ADDR_W-1:0];
                    end else if (stat.len == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EM_RD;
                        idx_next   = '0;
                    end
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SH_RD:  state_next = ST_SH_MUL;
            ST_SH_MUL: state_next = ST_SH_WR;
            ST_SH_WR: begin
                if (idx_last) begin
                    state_next = ST_EM_RD;
                    idx_next   = '0;
                end else begin
                    state_next = ST_SH_RD;
                    idx_next   = idx_reg + 6'd1;
                end
            end
            ST_EM_RD:  state_next = ST_EM_LD;
            ST_EM_LD: begin
                if (stat.out_free) begin
                    if (idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EM_RD;
                        idx_next   = idx_reg + 6'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    // Sharpening only touches taps between the lag and the length
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sh_we |-> (({1'b0, idx_reg} >= stat.lag) && (idx_reg < stat.len)))
        else $error("sharpening index out of range");

    // Emission never runs past the subframe
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (idx_reg < stat.len))
        else $error("emission index past length");

    // An accepted beat starts placement in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.place_we)
        else $error("placement did not follow accept");

endmodule

### sv/acfcd_datapath.sv
`timescale 1ns / 1ps

module acfcd_datapath #(
    parameter int MAX_SUB_LEN = acfcd_pkg::MAX_SUB_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [acfcd_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tuser,
    input  acfcd_pkg::acfcd_cmd_t                 cmd,
    output acfcd_pkg::acfcd_stat_t                stat,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [acfcd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast
);

    localparam int AW = acfcd_pkg::ADDR_W;
    localparam int SW = acfcd_pkg::SAMPLE_W;

    // Latched item
    logic                           full_reg;
    logic [9:0]                     w0_reg;
    logic [7:0]                     w1_reg;
    logic [7:0]                     w2_reg;
    logic [10:0]                    w3_reg;
    logic [acfcd_pkg::GAIN_W-1:0]   gain_reg;
    logic [acfcd_pkg::LAG_W-1:0]    lag_reg;
    logic [acfcd_pkg::LEN_W-1:0]    len_reg;

    // Unpacked input fields
    logic [acfcd_pkg::GAIN_W-1:0]   in_gain;
    logic [acfcd_pkg::LEN_W-1:0]    in_len;

    // Pulse buffer with per-entry valid bits
    logic signed [SW-1:0]           mem [acfcd_pkg::BUF_DEPTH];
    logic [acfcd_pkg::BUF_DEPTH-1:0] valid_reg;
    logic signed [SW-1:0]           rda_reg;
    logic signed [SW-1:0]           rdb_reg;
    logic [AW-1:0]                  addr_b;
    logic [6:0]                     diff_b;

    // Write port
    logic                           wr_en;
    logic [AW-1:0]                  waddr;
    logic signed [SW-1:0]           wdata;

    // Placement decode
    logic [7:0]                     pw;
    logic [2:0]                     trk;
    logic [1:0]                     off;
    logic [AW-1:0]                  p1;
    logic [AW-1:0]                  p2;
    logic signed [SW-1:0]           ps;
    logic signed [SW-1:0]           place_data;
    logic [AW-1:0]                  place_addr;
    logic signed [SW-1:0]           hs;

    // Sharpening arithmetic
    logic signed [31:0]             prod_reg;
    logic signed [31:0]             rnd;
    logic signed [16:0]             add17;
    logic signed [16:0]             sum17;
    logic signed [SW-1:0]           sum_sat;

    // Output register
    logic                           m_valid_reg;
    logic signed [SW-1:0]           sample_reg;
    logic                           last_reg;

    // Unpack and clip the incoming beat
    assign in_gain = s_tdata[51:37];
    assign in_len  = s_tdata[64:59];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            full_reg <= s_tuser;
            w0_reg   <= s_tdata[9:0];
            w1_reg   <= s_tdata[17:10];
            w2_reg   <= s_tdata[25:18];
            w3_reg   <= s_tdata[36:26];
            lag_reg  <= s_tdata[58:52];
            if (in_gain < acfcd_pkg::GAIN_MIN) begin
                gain_reg <= acfcd_pkg::GAIN_MIN;
            end else if (in_gain > acfcd_pkg::GAIN_MAX) begin
                gain_reg <= acfcd_pkg::GAIN_MAX;
            end else begin
                gain_reg <= in_gain;
            end
            if (in_len > acfcd_pkg::LEN_W'(MAX_SUB_LEN)) begin
                len_reg <= acfcd_pkg::LEN_W'(MAX_SUB_LEN);
            end else begin
                len_reg <= in_len;
            end
        end
    end

    // Decode one pulse write per placement step
    assign off = w3_reg[10:9];
    assign hs  = w0_reg[9] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;

    always_comb begin
        case (cmd.place_step[2:1])
            2'd0:    pw = w0_reg[7:0];
            2'd1:    pw = w1_reg;
            default: pw = w2_reg;
        endcase
        trk = acfcd_pkg::track5({1'b0, cmd.place_step[2:1]}, off);
        p1  = acfcd_pkg::track_pos(acfcd_pkg::div11(pw[6:0]), trk);
        p2  = acfcd_pkg::track_pos(acfcd_pkg::mod11(pw[6:0]), trk);
        ps  = pw[7] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
        place_addr = '0;
        place_data = '0;
        if (full_reg) begin
            case (cmd.place_step)
                3'd6: begin
                    place_addr = acfcd_pkg::track_pos(acfcd_pkg::div11(w3_reg[6:0]),
                                                      acfcd_pkg::track5(3'd3, off));
                    place_data = w3_reg[8] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
                end
                3'd7: begin
                    place_addr = acfcd_pkg::track_pos(acfcd_pkg::mod11(w3_reg[6:0]),
                                                      acfcd_pkg::track5(3'd4, off));
                    place_data = w3_reg[7] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
                end
                default: begin
                    if (!cmd.place_step[0]) begin
                        place_addr = p1;
                        place_data = ps;
                    end else begin
                        // second pulse: mirrored if earlier, doubled if on top
                        place_addr = p2;
                        if (p2 < p1) begin
                            place_data = -ps;
                        end else if (p2 == p1) begin
                            place_data = pw[7] ? -acfcd_pkg::PULSE_TWO : acfcd_pkg::PULSE_TWO;
                        end else begin
                            place_data = ps;
                        end
                    end
                end
            endcase
        end else begin
            case (cmd.place_step)
                3'd0: begin
                    place_addr = ({3'd0, w0_reg[2:0]} * 6'd7) + 6'd4;
                    place_data = hs;
                end
                3'd1: begin
                    place_addr = ({3'd0, w0_reg[5:3]} * 6'd7) + 6'd2;
                    place_data = -hs;
                end
                default: begin
                    place_addr = {3'd0, w0_reg[8:6]} * 6'd7;
                    place_data = hs;
                end
            endcase
        end
    end

    // Round the tap product and add with saturation
    assign rnd   = prod_reg + acfcd_pkg::ROUND_HALF;
    assign add17 = rnd[31:15];
    assign sum17 = {rda_reg[SW-1], rda_reg} + add17;

    always_comb begin
        if (sum17 > 17'sd32767) begin
            sum_sat = 16'sh7fff;
        end else if (sum17 < -17'sd32768) begin
            sum_sat = 16'sh8000;
        end else begin
            sum_sat = sum17[SW-1:0];
        end
    end

    // Select the single write port
    assign wr_en = cmd.place_we || cmd.sh_we;
    assign waddr = cmd.sh_we ? cmd.idx : place_addr;
    assign wdata = cmd.sh_we ? sum_sat : place_data;

    assign diff_b = {1'b0, cmd.idx} - lag_reg;
    assign addr_b = diff_b[AW-1:0];

    // Clear valid bits per item, mark written entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.load) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Buffer memory with registered reads; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_a) begin
            rda_reg <= valid_reg[cmd.idx] ? mem[cmd.idx] : '0;
        end
        if (cmd.rd_b) begin
            rdb_reg <= valid_reg[addr_b] ? mem[addr_b] : '0;
        end
    end

    // Register the gain product
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= $signed({1'b0, gain_reg}) * rdb_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            sample_reg <= rda_reg;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sample_reg;
    assign m_tlast  = last_reg;

    assign stat.full_rate = full_reg;
    assign stat.len       = len_reg;
    assign stat.lag       = lag_reg;
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Never overwrite a sample that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");

    // Every write lands inside the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (waddr < AW'(acfcd_pkg::BUF_DEPTH)))
        else $error("buffer write out of range");

    // The product is always formed from a fresh tap read
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> $past(cmd.rd_b))
        else $error("multiply without tap read");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 126;
    localparam int PAUSE_AT       = RANDOM_ITEMS / 2;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER     = 60;
    localparam int TAIL_CYCLES    = 64;

    localparam bit MODE_HALF = 1'b0;
    localparam bit MODE_FULL = 1'b1;

    // One subframe's worth of codebook indices and sharpening controls
    typedef struct packed {
        logic                         full_rate;
        logic [9:0]                   w0;
        logic [7:0]                   w1;
        logic [7:0]                   w2;
        logic [10:0]                  w3;
        logic [acfcd_pkg::GAIN_W-1:0] gain;
        logic [acfcd_pkg::LAG_W-1:0]  lag;
        logic [acfcd_pkg::LEN_W-1:0]  len;
    } subframe_t;

    // One excitation sample as it should leave the block
    typedef struct packed {
        logic signed [acfcd_pkg::SAMPLE_W-1:0] sample;
        logic                                  last;
    } exc_t;

    // Directed row: either predicted, or carrying a hand-written single sample
    typedef struct {
        subframe_t                             sf;
        bit                                    typed;
        logic signed [acfcd_pkg::SAMPLE_W-1:0] typed_sample;
    } row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [acfcd_pkg::S_TDATA_W-1:0] s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [acfcd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    exc_t exc_expected[$];
    exc_t exc_head;
    row_t row_q[$];
    int   err_cnt    = 0;
    int   beats_in   = 0;
    int   burst_left = 0;

    acelp_fixed_codebook_decode uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Saturate to the 16-bit sample range
    function automatic logic signed [acfcd_pkg::SAMPLE_W-1:0] sat_q12(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[acfcd_pkg::SAMPLE_W-1:0];
    endfunction

    // Build the pulse buffer, sharpen it and queue the samples it yields
    function automatic void predict_excitation(input subframe_t sf);
        logic signed [acfcd_pkg::SAMPLE_W-1:0] pbuf [0:acfcd_pkg::BUF_DEPTH-1];
        logic [7:0] w;
        int n, off, trk, p1, p2, k, sgn, gain_q15, prod;
        exc_t e;
        for (k = 0; k < acfcd_pkg::BUF_DEPTH; k++) begin
            pbuf[k] = '0;
        end
        n = (int'(sf.len) > acfcd_pkg::MAX_SUB_LEN_DEF) ? acfcd_pkg::MAX_SUB_LEN_DEF
                                                         : int'(sf.len);

        if (sf.full_rate) begin
            off = int'(sf.w3[10:9]);
            // three paired tracks: second pulse takes the opposite sign if earlier, else adds
            for (k = 0; k < 3; k++) begin
                w   = (k == 0) ? sf.w0[7:0] : (k == 1) ? sf.w1 : sf.w2;
                trk = (k + off) % 5;
                p1  = (int'(w[6:0]) / 11) * 5 + trk;
                p2  = (int'(w[6:0]) % 11) * 5 + trk;
                pbuf[p1] = w[7] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
                if (p2 < p1) begin
                    pbuf[p2] = sat_q12(-int'(pbuf[p1]));
                end else begin
                    pbuf[p2] = sat_q12(int'(pbuf[p2]) + int'(pbuf[p1]));
                end
            end
            // two single pulses on the remaining tracks
            p1 = (int'(sf.w3[6:0]) / 11) * 5 + (3 + off) % 5;
            p2 = (int'(sf.w3[6:0]) % 11) * 5 + (4 + off) % 5;
            pbuf[p1] = sf.w3[8] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
            pbuf[p2] = sf.w3[7] ? -acfcd_pkg::PULSE_ONE : acfcd_pkg::PULSE_ONE;
        end else begin
            sgn = sf.w0[9] ? -int'(acfcd_pkg::PULSE_ONE) : int'(acfcd_pkg::PULSE_ONE);
            p1 = int'(sf.w0[2:0]) * 7 + 4;
            pbuf[p1] = sat_q12(int'(pbuf[p1]) + sgn);
            p1 = int'(sf.w0[5:3]) * 7 + 2;
            pbuf[p1] = sat_q12(int'(pbuf[p1]) - sgn);
            p1 = int'(sf.w0[8:6]) * 7;
            pbuf[p1] = sat_q12(int'(pbuf[p1]) + sgn);
        end

        // clip the gain, then run the recursive sharpening taps
        gain_q15 = int'(sf.gain);
        if (gain_q15 < int'(acfcd_pkg::GAIN_MIN)) begin
            gain_q15 = int'(acfcd_pkg::GAIN_MIN);
        end
        if (gain_q15 > int'(acfcd_pkg::GAIN_MAX)) begin
            gain_q15 = int'(acfcd_pkg::GAIN_MAX);
        end
        if (sf.lag != 0) begin
            for (k = int'(sf.lag); k < n; k++) begin
                prod    = gain_q15 * int'(pbuf[k - int'(sf.lag)]);
                pbuf[k] = sat_q12(int'(pbuf[k]) + ((prod + 16384) >>> 15));
            end
        end

        for (k = 0; k < n; k++) begin
            e.sample = pbuf[k];
            e.last   = (k == n - 1);
            exc_expected.push_back(e);
        end
    endfunction

    function automatic void add_row(input bit rate, input int w0, input int w1, input int w2,
                                    input int w3, input int gain, input int lag, input int len,
                                    input bit typed = 1'b0, input int typed_sample = 0);
        row_t r;
        r.sf.full_rate  = rate;
        r.sf.w0         = w0[9:0];
        r.sf.w1         = w1[7:0];
        r.sf.w2         = w2[7:0];
        r.sf.w3         = w3[10:0];
        r.sf.gain       = gain[acfcd_pkg::GAIN_W-1:0];
        r.sf.lag        = lag[acfcd_pkg::LAG_W-1:0];
        r.sf.len        = len[acfcd_pkg::LEN_W-1:0];
        r.typed         = typed;
        r.typed_sample  = typed_sample[acfcd_pkg::SAMPLE_W-1:0];
        row_q.push_back(r);
    endfunction

    // Offer one beat in bursts with random gaps, return at acceptance
    task automatic send_subframe(input subframe_t sf);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sf.full_rate;
        s_tdata  <= {7'd0, sf.len, sf.lag, sf.gain, sf.w3, sf.w2, sf.w1, sf.w0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_in++;
        burst_left--;
    endtask

    // Sender: directed table, then random subframes, then drain
    initial begin : tx_side
        row_t      r;
        subframe_t sf;
        int        k;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;

        // lone pulses and doubled pulses at the origin, hand-checked
        add_row(MODE_HALF, 'h000, 0, 0, 0, 0, 0, 1, 1'b1, 4096);
        add_row(MODE_HALF, 'h200, 0, 0, 0, 0, 0, 1, 1'b1, -4096);
        add_row(MODE_FULL, 'h000, 0, 0, 0, 0, 0, 1, 1'b1, 8192);
        add_row(MODE_FULL, 'h080, 0, 0, 0, 0, 0, 1, 1'b1, -8192);
        // zero length gives nothing
        add_row(MODE_HALF, 'h3ff, 'hff, 'hff, 'h7ff, 32767, 1, 0, 1'b1, 0);
        // all-ones words, long length clipped, unused bits set
        add_row(MODE_FULL, 'h3ff, 'hff, 'hff, 'h7ff, 32767, 1, 63);
        add_row(MODE_HALF, 'h3ff, 'hff, 'hff, 'h7ff, 32767, 1, 54);
        add_row(MODE_HALF, 'h1ff, 0, 0, 0, 0, 7, 54);
        // every track offset
        add_row(MODE_FULL, 'h02d, 'h93, 'h17, 'h12d, 16384, 5, 54);
        add_row(MODE_FULL, 'h02d, 'h93, 'h17, 'h2ad, 16384, 5, 54);
        add_row(MODE_FULL, 'h02d, 'h93, 'h17, 'h42d, 16384, 5, 54);
        add_row(MODE_FULL, 'h02d, 'h93, 'h17, 'h7ad, 16384, 5, 54);
        // second pulse before the first takes the opposite sign, after it adds
        add_row(MODE_FULL, 57, 'h92, 'h0c, 'h155, 20000, 20, 40);
        add_row(MODE_FULL, 'h180, 18, 'h92, 'h0c4, 12000, 40, 54);
        // gain on and just beyond both clip limits
        add_row(MODE_HALF, 'h0a5, 0, 0, 0, 6554, 3, 54);
        add_row(MODE_FULL, 'h024, 'h51, 'h6e, 'h3a9, 29491, 3, 54);
        add_row(MODE_HALF, 'h2da, 0, 0, 0, 6553, 2, 54);
        add_row(MODE_FULL, 'h077, 'h08, 'hc3, 'h5f0, 29492, 2, 54);
        // lag equal to length, maximal lag, zero lag
        add_row(MODE_HALF, 'h137, 0, 0, 0, 25000, 30, 30);
        add_row(MODE_FULL, 'h044, 'h3b, 'h9a, 'h21f, 25000, 127, 54);
        add_row(MODE_FULL, 'h0d1, 'h2e, 'hf0, 'h61a, 25000, 0, 54);
        // length just over the cap, single tap, short subframe
        add_row(MODE_HALF, 'h3c8, 'h55, 'haa, 'h555, 9000, 4, 55);
        add_row(MODE_FULL, 'h05e, 'h7f, 'h80, 'h400, 30000, 53, 54);
        add_row(MODE_HALF, 'h0ff, 0, 0, 0, 18000, 1, 2);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < row_q.size(); k++) begin
            r = row_q[k];
            send_subframe(r.sf);
            if (!r.typed) begin
                predict_excitation(r.sf);
            end else if (r.sf.len != 0) begin
                exc_expected.push_back('{r.typed_sample, 1'b1});
            end
        end

        // let the directed part drain completely
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (exc_expected.size() != 0);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            sf.full_rate = 1'($urandom_range(0, 1));
            sf.w0        = 10'($urandom_range(0, 1023));
            sf.w1        = 8'($urandom_range(0, 255));
            sf.w2        = 8'($urandom_range(0, 255));
            sf.w3        = 11'($urandom_range(0, 2047));
            case ($urandom_range(0, 9))
                0:       sf.gain = 15'($urandom_range(0, 6553));
                1:       sf.gain = 15'($urandom_range(29492, 32767));
                default: sf.gain = 15'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 9))
                0:       sf.lag = '0;
                1, 2:    sf.lag = 7'($urandom_range(1, 8));
                3:       sf.lag = 7'($urandom_range(55, 127));
                default: sf.lag = 7'($urandom_range(1, 54));
            endcase
            case ($urandom_range(0, 9))
                0:       sf.len = '0;
                1:       sf.len = 6'($urandom_range(55, 63));
                2, 3:    sf.len = 6'(acfcd_pkg::MAX_SUB_LEN_DEF);
                default: sf.len = 6'($urandom_range(1, 54));
            endcase
            send_subframe(sf);
            predict_excitation(sf);

            // pause midway until every sample is back
            if (k == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (exc_expected.size() != 0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (exc_expected.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: stall in spans of random density, with one long hold-off
    initial begin : rx_side
        int span;
        int pct;
        bit hold_done;
        m_tready <= 1'b0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            span = $urandom_range(4, 48);
            case ($urandom_range(0, 3))
                0:       pct = 100;
                1:       pct = 80;
                2:       pct = 50;
                default: pct = 20;
            endcase
            repeat (span) begin
                @(posedge aclk);
                m_tready <= ($urandom_range(1, 100) <= pct);
            end
            if (!hold_done && beats_in >= HOLD_AFTER) begin
                hold_done = 1'b1;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // Compare each accepted sample beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (exc_expected.size() == 0) begin
                $error("sample: expected none, actual %0d", $signed(m_tdata));
                err_cnt++;
            end else begin
                exc_head = exc_expected.pop_front();
                if (m_tdata !== exc_head.sample) begin
                    $error("sample: expected %0d, actual %0d",
                           $signed(exc_head.sample), $signed(m_tdata));
                    err_cnt++;
                end
                if (m_tlast !== exc_head.last) begin
                    $error("last: expected %0d, actual %0d", exc_head.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
